// ===== rtl/core/ctqr_pkg.sv =====
package ctqr_pkg;

  localparam int unsigned POOL_DEPTH = 16;
  localparam int unsigned PTR_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned IDX_W      = $clog2(POOL_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [PTR_W-1:0] ptr_t;

  localparam idx_t NIL_IDX = idx_t'(POOL_DEPTH);
  localparam logic [31:0] REQ_BIT = 32'h0000_0001;

  typedef enum logic [3:0] {
    ST_QUEUED    = 4'd0,
    ST_OVERFLOW  = 4'd1,
    ST_SPURIOUS  = 4'd2,
    ST_SENT      = 4'd3,
    ST_RETRY_ERR = 4'd4,
    ST_DROP_ERR  = 4'd5,
    ST_RETRY_ARB = 4'd6,
    ST_DROP_ARB  = 4'd7,
    ST_NO_FLAG   = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_SET_STATUS,
    CMD_ALLOC,
    CMD_WALK_STEP,
    CMD_LINK,
    CMD_RETRY_INC,
    CMD_REM_START,
    CMD_REM_STEP,
    CMD_REM_LINK,
    CMD_LOAD_PREP,
    CMD_LOAD
  } cmd_e;

  typedef struct packed {
    cmd_e    op;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op;
    logic pool_full;
    logic spurious;
    logic tx_ok;
    logic tx_err;
    logic arb;
    logic retry_over;
    logic no_retry;
    logic cur_valid;
    logic id_lt;
    logic cur_is_flight;
    logic flight_valid;
  } dp_stat_t;

endpackage

// ===== rtl/core/ctqr_ctrl.sv =====
module ctqr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ctqr_pkg::dp_stat_t  stat_i,
  output ctqr_pkg::ctrl_cmd_t cmd_o,
  output logic                busy_o,
  output logic                result_valid_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_REM_START,
    S_REM_WALK,
    S_LOAD_PREP,
    S_LOAD,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = ctqr_pkg::CMD_NONE;
    cmd_o.status  = ctqr_pkg::ST_QUEUED;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = ctqr_pkg::CMD_CAPTURE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat_i.op) begin
          if (stat_i.pool_full) begin
            cmd_o.op     = ctqr_pkg::CMD_SET_STATUS;
            cmd_o.status = ctqr_pkg::ST_OVERFLOW;
            state_d      = S_EMIT;
          end else begin
            cmd_o.op = ctqr_pkg::CMD_ALLOC;
            state_d  = S_WALK;
          end
        end else if (stat_i.spurious) begin
          cmd_o.op     = ctqr_pkg::CMD_SET_STATUS;
          cmd_o.status = ctqr_pkg::ST_SPURIOUS;
          state_d      = S_EMIT;
        end else if (stat_i.tx_ok) begin
          cmd_o.op     = ctqr_pkg::CMD_SET_STATUS;
          cmd_o.status = ctqr_pkg::ST_SENT;
          state_d      = S_REM_START;
        end else if (stat_i.tx_err) begin
          if (stat_i.retry_over) begin
            cmd_o.op     = ctqr_pkg::CMD_SET_STATUS;
            cmd_o.status = ctqr_pkg::ST_DROP_ERR;
            state_d      = S_REM_START;
          end else begin
            cmd_o.op     = ctqr_pkg::CMD_RETRY_INC;
            cmd_o.status = ctqr_pkg::ST_RETRY_ERR;
            state_d      = S_LOAD_PREP;
          end
        end else if (stat_i.arb) begin
          cmd_o.op = ctqr_pkg::CMD_SET_STATUS;
          if (stat_i.no_retry) begin
            cmd_o.status = ctqr_pkg::ST_DROP_ARB;
            state_d      = S_REM_START;
          end else begin
            cmd_o.status = ctqr_pkg::ST_RETRY_ARB;
            state_d      = S_LOAD_PREP;
          end
        end else begin
          cmd_o.op     = ctqr_pkg::CMD_SET_STATUS;
          cmd_o.status = ctqr_pkg::ST_NO_FLAG;
          state_d      = S_LOAD_PREP;
        end
      end
      S_WALK: begin
        if (stat_i.cur_valid && !stat_i.id_lt) begin
          cmd_o.op = ctqr_pkg::CMD_WALK_STEP;
        end else begin
          cmd_o.op     = ctqr_pkg::CMD_LINK;
          cmd_o.status = ctqr_pkg::ST_QUEUED;
          state_d      = stat_i.flight_valid ? S_EMIT : S_LOAD_PREP;
        end
      end
      S_REM_START: begin
        cmd_o.op = ctqr_pkg::CMD_REM_START;
        state_d  = S_REM_WALK;
      end
      S_REM_WALK: begin
        if (stat_i.cur_valid && !stat_i.cur_is_flight) begin
          cmd_o.op = ctqr_pkg::CMD_REM_STEP;
        end else begin
          if (stat_i.cur_valid) begin
            cmd_o.op = ctqr_pkg::CMD_REM_LINK;
          end
          state_d = S_LOAD_PREP;
        end
      end
      S_LOAD_PREP: begin
        cmd_o.op = ctqr_pkg::CMD_LOAD_PREP;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.op = ctqr_pkg::CMD_LOAD;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      valid_q <= (state_d == S_EMIT);
    end
  end

  assign busy_o         = busy_q;
  assign result_valid_o = valid_q;

endmodule

// ===== rtl/core/ctqr_dp.sv =====
module ctqr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctqr_pkg::ctrl_cmd_t cmd_i,
  output ctqr_pkg::dp_stat_t  stat_o,
  input  logic                op_i,
  input  logic [31:0]         msg_id_i,
  input  logic [3:0]          msg_dlc_i,
  input  logic [63:0]         msg_data_i,
  input  logic [7:0]          max_retry_i,
  input  logic                no_retry_i,
  input  logic                req_done_i,
  input  logic                tx_ok_i,
  input  logic                tx_error_i,
  input  logic                arb_lost_i,
  input  logic                other_box_done_i,
  output logic [3:0]          status_o,
  output logic                load_valid_o,
  output logic [31:0]         load_id_o,
  output logic [3:0]          load_dlc_o,
  output logic [63:0]         load_data_o
);

  localparam int unsigned D = ctqr_pkg::POOL_DEPTH;

  // entry store; read at one address (cur) per cycle
  logic [31:0]          id_q    [D];
  logic [3:0]           dlc_q   [D];
  logic [63:0]          data_q  [D];
  logic [7:0]           retr_q  [D];
  logic [7:0]           limit_q [D];
  logic                 nrt_q   [D];
  ctqr_pkg::idx_t       link_q  [D];

  ctqr_pkg::idx_t pend_q, free_q, flight_q, cur_q, prev_q, new_q;

  logic        op_q, nrt_in_q, req_q, ok_q, err_q, arb_q, other_q;
  logic [31:0] mid_q;
  logic [3:0]  mdlc_q;
  logic [63:0] mdata_q;
  logic [7:0]  mlim_q;

  logic [3:0]  status_q, ldlc_q;
  logic        lvalid_q;
  logic [31:0] lid_q;
  logic [63:0] ldata_q;

  ctqr_pkg::ptr_t cur_p, prev_p, new_p;
  logic           cur_ok, prev_ok, flight_ok;
  logic [8:0]     cnt;

  assign cur_p     = cur_q[ctqr_pkg::PTR_W-1:0];
  assign prev_p    = prev_q[ctqr_pkg::PTR_W-1:0];
  assign new_p     = new_q[ctqr_pkg::PTR_W-1:0];
  assign cur_ok    = (cur_q < ctqr_pkg::NIL_IDX);
  assign prev_ok   = (prev_q < ctqr_pkg::NIL_IDX);
  assign flight_ok = (flight_q < ctqr_pkg::NIL_IDX);
  assign cnt       = {1'b0, retr_q[cur_p]} + 9'd1;

  always_comb begin
    stat_o.op            = op_q;
    stat_o.pool_full     = !(free_q < ctqr_pkg::NIL_IDX);
    stat_o.spurious      = other_q || !req_q || !flight_ok;
    stat_o.tx_ok         = ok_q;
    stat_o.tx_err        = err_q;
    stat_o.arb           = arb_q;
    stat_o.retry_over    = (cnt > {1'b0, limit_q[cur_p]});
    stat_o.no_retry      = nrt_q[cur_p];
    stat_o.cur_valid     = cur_ok;
    stat_o.id_lt         = (mid_q < id_q[cur_p]);
    stat_o.cur_is_flight = (cur_q == flight_q);
    stat_o.flight_valid  = flight_ok;
  end

  // list control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) begin
        link_q[i] <= ctqr_pkg::idx_t'(i + 1);
      end
      pend_q   <= ctqr_pkg::NIL_IDX;
      free_q   <= '0;
      flight_q <= ctqr_pkg::NIL_IDX;
      cur_q    <= ctqr_pkg::NIL_IDX;
      prev_q   <= ctqr_pkg::NIL_IDX;
      new_q    <= ctqr_pkg::NIL_IDX;
    end else begin
      case (cmd_i.op)
        ctqr_pkg::CMD_CAPTURE: begin
          cur_q <= op_i ? flight_q : free_q;
        end
        ctqr_pkg::CMD_ALLOC: begin
          new_q  <= cur_q;
          free_q <= link_q[cur_p];
          cur_q  <= pend_q;
          prev_q <= ctqr_pkg::NIL_IDX;
        end
        ctqr_pkg::CMD_WALK_STEP, ctqr_pkg::CMD_REM_STEP: begin
          prev_q <= cur_q;
          cur_q  <= link_q[cur_p];
        end
        ctqr_pkg::CMD_LINK: begin
          link_q[new_p] <= cur_q;
          if (prev_ok) begin
            link_q[prev_p] <= new_q;
          end else begin
            pend_q <= new_q;
          end
        end
        ctqr_pkg::CMD_REM_START: begin
          cur_q  <= pend_q;
          prev_q <= ctqr_pkg::NIL_IDX;
        end
        ctqr_pkg::CMD_REM_LINK: begin
          if (prev_ok) begin
            link_q[prev_p] <= link_q[cur_p];
          end else begin
            pend_q <= link_q[cur_p];
          end
          link_q[cur_p] <= free_q;
          free_q        <= cur_q;
        end
        ctqr_pkg::CMD_LOAD_PREP: begin
          cur_q <= pend_q;
        end
        ctqr_pkg::CMD_LOAD: begin
          flight_q <= cur_ok ? cur_q : ctqr_pkg::NIL_IDX;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ctqr_pkg::CMD_CAPTURE: begin
        op_q     <= op_i;
        mid_q    <= msg_id_i;
        mdlc_q   <= msg_dlc_i;
        mdata_q  <= msg_data_i;
        mlim_q   <= max_retry_i;
        nrt_in_q <= no_retry_i;
        req_q    <= req_done_i;
        ok_q     <= tx_ok_i;
        err_q    <= tx_error_i;
        arb_q    <= arb_lost_i;
        other_q  <= other_box_done_i;
        status_q <= ctqr_pkg::ST_QUEUED;
        lvalid_q <= 1'b0;
        lid_q    <= '0;
        ldlc_q   <= '0;
        ldata_q  <= '0;
      end
      ctqr_pkg::CMD_SET_STATUS, ctqr_pkg::CMD_LINK: begin
        status_q <= cmd_i.status;
      end
      ctqr_pkg::CMD_RETRY_INC: begin
        status_q      <= cmd_i.status;
        retr_q[cur_p] <= cnt[7:0];
      end
      ctqr_pkg::CMD_ALLOC: begin
        id_q[cur_p]    <= mid_q;
        dlc_q[cur_p]   <= mdlc_q;
        data_q[cur_p]  <= mdata_q;
        limit_q[cur_p] <= mlim_q;
        nrt_q[cur_p]   <= nrt_in_q;
        retr_q[cur_p]  <= '0;
      end
      ctqr_pkg::CMD_LOAD: begin
        if (cur_ok) begin
          lvalid_q <= 1'b1;
          lid_q    <= id_q[cur_p] | ctqr_pkg::REQ_BIT;
          ldlc_q   <= dlc_q[cur_p];
          ldata_q  <= data_q[cur_p];
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o     = status_q;
  assign load_valid_o = lvalid_q;
  assign load_id_o    = lid_q;
  assign load_dlc_o   = ldlc_q;
  assign load_data_o  = ldata_q;

endmodule

// ===== rtl/core/can_tx_priority_queue_retry_top.sv =====
// CAN transmit priority queue for a single mailbox.
// Command channel: an item transfers at a rising edge with start_i high and
// busy_o low. op_i = 0 enqueues a frame (msg_* fields, max_retry_i,
// no_retry_i); op_i = 1 reports the mailbox outcome (req_done_i, tx_ok_i,
// tx_error_i, arb_lost_i, other_box_done_i).
// Result channel: each item gives exactly one result, shown on status_o and
// load_*_o for one cycle while result_valid_o is high. The receiver cannot
// stall; take the result in that cycle or lose it. When load_valid_o is high
// the mailbox gets load_id_o (request bit set), load_dlc_o and load_data_o.
// Overflow and spurious answers go straight to the result. An enqueue
// allocates an entry and walks the pending list to its sorted place; behind
// a busy mailbox it then gives its result, and into an idle mailbox it first
// loads the mailbox. A removal walks the pending list to the in-flight frame,
// unlinks it and then loads the mailbox from the pending head. The sorted
// insert and the removal walk the pending list one entry per cycle through
// the single read port of the entry store, so the walk length sets how long
// an item takes. One item is worked on at a time; busy_o drops the cycle
// after the strobe, so the next transfer can follow in that cycle.
// Reset: the free list is rebuilt in index order at once, the pending list
// is empty and the mailbox is idle. No clearing pass is needed.
module can_tx_priority_queue_retry_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [31:0] msg_id_i,
  input  logic [3:0]  msg_dlc_i,
  input  logic [63:0] msg_data_i,
  input  logic [7:0]  max_retry_i,
  input  logic        no_retry_i,
  input  logic        req_done_i,
  input  logic        tx_ok_i,
  input  logic        tx_error_i,
  input  logic        arb_lost_i,
  input  logic        other_box_done_i,
  output logic        result_valid_o,
  output logic [3:0]  status_o,
  output logic        load_valid_o,
  output logic [31:0] load_id_o,
  output logic [3:0]  load_dlc_o,
  output logic [63:0] load_data_o
);

  // command and status between sequencer and list datapath
  ctqr_pkg::ctrl_cmd_t cmd;
  ctqr_pkg::dp_stat_t  stat;

  ctqr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  ctqr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_i             (op_i),
    .msg_id_i         (msg_id_i),
    .msg_dlc_i        (msg_dlc_i),
    .msg_data_i       (msg_data_i),
    .max_retry_i      (max_retry_i),
    .no_retry_i       (no_retry_i),
    .req_done_i       (req_done_i),
    .tx_ok_i          (tx_ok_i),
    .tx_error_i       (tx_error_i),
    .arb_lost_i       (arb_lost_i),
    .other_box_done_i (other_box_done_i),
    .status_o         (status_o),
    .load_valid_o     (load_valid_o),
    .load_id_o        (load_id_o),
    .load_dlc_o       (load_dlc_o),
    .load_data_o      (load_data_o)
  );

endmodule

// ===== rtl/core/ctqr_checker.sv =====
module ctqr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [3:0]  status_o,
  input logic        load_valid_o,
  input logic [31:0] load_id_o
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !result_valid_o))
    else $error("transfer not followed by busy");

  a_valid_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result outside busy window");

  a_load_req_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && load_valid_o) |-> load_id_o[0])
    else $error("loaded id lacks request bit");

  a_load_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && load_valid_o) |->
      (status_o != ctqr_pkg::ST_OVERFLOW && status_o != ctqr_pkg::ST_SPURIOUS))
    else $error("load on overflow or spurious result");

endmodule

bind can_tx_priority_queue_retry_top ctqr_checker u_ctqr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .load_valid_o   (load_valid_o),
  .load_id_o      (load_id_o)
);

// ===== test/ctqr_checker.sv =====
`timescale 1ns / 1ps

module ctqr_scoreboard
  import ctqr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        op_i,
  input  logic [31:0] msg_id_i,
  input  logic [3:0]  msg_dlc_i,
  input  logic [63:0] msg_data_i,
  input  logic [7:0]  max_retry_i,
  input  logic        no_retry_i,
  input  logic        req_done_i,
  input  logic        tx_ok_i,
  input  logic        tx_error_i,
  input  logic        arb_lost_i,
  input  logic        other_box_done_i,
  input  logic        result_valid_i,
  input  logic [3:0]  status_i,
  input  logic        load_valid_i,
  input  logic [31:0] load_id_i,
  input  logic [3:0]  load_dlc_i,
  input  logic [63:0] load_data_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  localparam int EMPTY = POOL_DEPTH;

  typedef struct packed {
    logic [3:0]  status;
    logic        load_valid;
    logic [31:0] load_id;
    logic [3:0]  load_dlc;
    logic [63:0] load_data;
  } outcome_t;

  logic [31:0] q_id    [POOL_DEPTH];
  logic [3:0]  q_dlc   [POOL_DEPTH];
  logic [63:0] q_data  [POOL_DEPTH];
  logic [7:0]  q_tries [POOL_DEPTH];
  logic [7:0]  q_limit [POOL_DEPTH];
  logic        q_noretry [POOL_DEPTH];
  int          q_next  [POOL_DEPTH];
  int          pend_head, free_head, flight;
  outcome_t    awaited [$];

  function automatic outcome_t load_mailbox(outcome_t o);
    if (pend_head == EMPTY) begin
      flight = EMPTY;
    end else begin
      flight       = pend_head;
      o.load_valid = 1'b1;
      o.load_id    = q_id[pend_head] | REQ_BIT;
      o.load_dlc   = q_dlc[pend_head];
      o.load_data  = q_data[pend_head];
    end
    return o;
  endfunction

  // Unlink the in-flight frame and return its entry to the free list.
  function automatic void retire_flight();
    int prev, cur;
    prev = EMPTY;
    cur  = pend_head;
    while (cur != EMPTY && cur != flight) begin
      prev = cur;
      cur  = q_next[cur];
    end
    if (cur == EMPTY) return;
    if (prev != EMPTY) q_next[prev] = q_next[cur];
    else pend_head = q_next[cur];
    q_next[cur] = free_head;
    free_head   = cur;
  endfunction

  function automatic outcome_t queue_step();
    outcome_t o;
    int n, prev, cur;
    o = '0;
    if (!op_i) begin
      n = free_head;
      if (n == EMPTY) begin
        o.status = ST_OVERFLOW;
        return o;
      end
      free_head    = q_next[n];
      q_id[n]      = msg_id_i;
      q_dlc[n]     = msg_dlc_i;
      q_data[n]    = msg_data_i;
      q_limit[n]   = max_retry_i;
      q_noretry[n] = no_retry_i;
      q_tries[n]   = '0;
      // Equal ids go behind the ones already queued.
      prev = EMPTY;
      cur  = pend_head;
      while (cur != EMPTY && !(msg_id_i < q_id[cur])) begin
        prev = cur;
        cur  = q_next[cur];
      end
      q_next[n] = cur;
      if (prev != EMPTY) q_next[prev] = n;
      else pend_head = n;
      o.status = ST_QUEUED;
      if (flight == EMPTY) o = load_mailbox(o);
      return o;
    end
    if (other_box_done_i || !req_done_i || flight == EMPTY) begin
      o.status = ST_SPURIOUS;
      return o;
    end
    if (tx_ok_i) begin
      retire_flight();
      o.status = ST_SENT;
    end else if (tx_error_i) begin
      if ({1'b0, q_tries[flight]} + 9'd1 > {1'b0, q_limit[flight]}) begin
        retire_flight();
        o.status = ST_DROP_ERR;
      end else begin
        q_tries[flight] = q_tries[flight] + 8'd1;
        o.status = ST_RETRY_ERR;
      end
    end else if (arb_lost_i) begin
      if (q_noretry[flight]) begin
        retire_flight();
        o.status = ST_DROP_ARB;
      end else begin
        o.status = ST_RETRY_ARB;
      end
    end else begin
      o.status = ST_NO_FLAG;
    end
    return load_mailbox(o);
  endfunction

  function automatic void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    fail_count_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      for (int i = 0; i < POOL_DEPTH; i++) q_next[i] = i + 1;
      pend_head     = EMPTY;
      free_head     = 0;
      flight        = EMPTY;
      fail_count_o  = 0;
      awaited.delete();
      outstanding_o = 0;
    end else begin
      // Compare first: a result never shares an edge with a new transfer.
      if (result_valid_i) begin
        if (awaited.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d", $time, status_i);
          fail_count_o++;
        end else begin
          e = awaited.pop_front();
          if (status_i !== e.status) report("status", 64'(e.status), 64'(status_i));
          if (load_valid_i !== e.load_valid) begin
            report("load_valid", 64'(e.load_valid), 64'(load_valid_i));
          end
          if (load_id_i !== e.load_id) report("load_id", 64'(e.load_id), 64'(load_id_i));
          if (load_dlc_i !== e.load_dlc) begin
            report("load_dlc", 64'(e.load_dlc), 64'(load_dlc_i));
          end
          if (load_data_i !== e.load_data) report("load_data", e.load_data, load_data_i);
        end
      end
      if (start_i && !busy_i) awaited.push_back(queue_step());
      outstanding_o = awaited.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ctqr_pkg::*;

  typedef struct {
    logic        op;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic [7:0]  max_retry;
    logic        no_retry;
    logic        req_done;
    logic        tx_ok;
    logic        tx_error;
    logic        arb_lost;
    logic        other_done;
  } frame_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        op_i = 1'b0;
  logic [31:0] msg_id_i = '0;
  logic [3:0]  msg_dlc_i = '0;
  logic [63:0] msg_data_i = '0;
  logic [7:0]  max_retry_i = '0;
  logic        no_retry_i = 1'b0;
  logic        req_done_i = 1'b0;
  logic        tx_ok_i = 1'b0;
  logic        tx_error_i = 1'b0;
  logic        arb_lost_i = 1'b0;
  logic        other_box_done_i = 1'b0;
  logic        busy_o, result_valid_o, load_valid_o;
  logic [3:0]  status_o, load_dlc_o;
  logic [31:0] load_id_o;
  logic [63:0] load_data_o;
  int          fail_count, outstanding;
  int          sent_count;

  always #4 clk_i = ~clk_i;

  can_tx_priority_queue_retry_top i_dut (.*);

  ctqr_scoreboard i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .msg_id_i, .msg_dlc_i,
    .msg_data_i, .max_retry_i, .no_retry_i, .req_done_i, .tx_ok_i, .tx_error_i,
    .arb_lost_i, .other_box_done_i, .result_valid_i(result_valid_o),
    .status_i(status_o), .load_valid_i(load_valid_o), .load_id_i(load_id_o),
    .load_dlc_i(load_dlc_o), .load_data_i(load_data_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  // Drive one command at the falling edge, hold it until busy is low, and
  // return right after the rising edge that completes the transfer.
  task automatic send(frame_cmd_t c);
    @(negedge clk_i);
    start_i          <= 1'b1;
    op_i             <= c.op;
    msg_id_i         <= c.id;
    msg_dlc_i        <= c.dlc;
    msg_data_i       <= c.data;
    max_retry_i      <= c.max_retry;
    no_retry_i       <= c.no_retry;
    req_done_i       <= c.req_done;
    tx_ok_i          <= c.tx_ok;
    tx_error_i       <= c.tx_error;
    arb_lost_i       <= c.arb_lost;
    other_box_done_i <= c.other_done;
    #1;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    sent_count++;
  endtask

  // Drop start for a random number of cycles: mostly none, a few long gaps.
  task automatic pause();
    int n, r;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n == 0) return;
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic frame_cmd_t rand_frame();
    frame_cmd_t c;
    c.op   = 1'b0;
    // Narrow ids often, so that ties and reordering happen.
    c.id   = ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 7)) << 3;
    c.dlc  = 4'($urandom_range(0, 15));
    c.data = {$urandom, $urandom};
    c.max_retry = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 3));
    c.no_retry  = 1'($urandom_range(0, 1));
    {c.req_done, c.tx_ok, c.tx_error, c.arb_lost, c.other_done} = 5'($urandom);
    return c;
  endfunction

  function automatic frame_cmd_t completion(bit ok, bit err, bit arb);
    frame_cmd_t c;
    c = rand_frame();
    c.op = 1'b1;
    c.req_done = 1'b1;
    c.other_done = 1'b0;
    c.tx_ok = ok;
    c.tx_error = err;
    c.arb_lost = arb;
    return c;
  endfunction

  function automatic frame_cmd_t rand_completion();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return completion(1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    if (r < 60) return completion(0, 1, 1'($urandom_range(0, 1)));
    if (r < 85) return completion(0, 0, 1);
    return completion(0, 0, 0);
  endfunction

  // Hold off until every result is in, drain the queue so that the run
  // starts from a known frame, then retry that frame past its limit.
  task automatic drain_and_retry();
    frame_cmd_t c;
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (outstanding == 0);
    repeat (20) send(completion(1, 0, 0));
    c = rand_frame(); c.max_retry = 8'hff; c.id = '0;
    send(c);
    repeat (257) send(completion(0, 1, 0));
  endtask

  initial begin
    frame_cmd_t c;
    int r;
    sent_count = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: completion while idle, extreme frames, a higher priority
    // arrival, equal ids, and the flag precedence cases.
    send(completion(1, 0, 0));
    c = rand_frame();
    c.id = '1; c.dlc = 4'hf; c.data = '1; c.max_retry = 8'hff; c.no_retry = 1'b1;
    send(c);
    c.id = '0; c.dlc = '0; c.data = '0; c.max_retry = '0; c.no_retry = 1'b0;
    send(c);
    send(c);
    c = completion(1, 0, 0); c.other_done = 1'b1; send(c);
    c = completion(1, 0, 0); c.req_done = 1'b0;   send(c);
    send(completion(0, 0, 0));
    send(completion(0, 1, 1));
    send(completion(1, 1, 1));
    send(completion(0, 0, 1));
    send(completion(0, 1, 0));
    send(completion(0, 0, 1));
    send(completion(0, 0, 1));

    drain_and_retry();

    while (sent_count < 950) begin
      r = $urandom_range(0, 999);
      if (r < 3) begin
        drain_and_retry();
      end else if (r < 30) begin
        // Burst of enqueues to reach the full pool.
        repeat (18) begin
          send(rand_frame());
          pause();
        end
      end else if (r < 470) begin
        send(rand_frame());
      end else if (r < 880) begin
        send(rand_completion());
      end else begin
        c = rand_frame();
        c.op = 1'b1;
        send(c);
      end
      pause();
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    wait (outstanding == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

endmodule
